@@ src/udp_port_range_packet_classifier_macros.svh @@
// Assertion helpers for the UDP port range classifier.
`ifndef UDP_PORT_RANGE_PACKET_CLASSIFIER_MACROS_SVH
`define UDP_PORT_RANGE_PACKET_CLASSIFIER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, held off during reset.
`define UDPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("udpc: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define UDPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("udpc: next-cycle check failed");

`else

`define UDPC_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define UDPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ src/udpc_pkg.sv @@
`timescale 1ns / 1ps

package udpc_pkg;

    localparam int POS_W           = 14;
    localparam int MAX_FRAME_BYTES = 16383;
    localparam int QUEUE_SLOTS     = 64;
    localparam int QUEUE_IDX_W     = 6;
    localparam int CNT_W           = 48;

    // Verdict codes
    localparam logic [1:0] VERDICT_PASS     = 2'd0;
    localparam logic [1:0] VERDICT_DROP     = 2'd1;
    localparam logic [1:0] VERDICT_REDIRECT = 2'd2;

    // Register indexes (byte address is 8 * index)
    localparam logic [1:0] REG_PORT_LOW   = 2'd0;
    localparam logic [1:0] REG_PORT_HIGH  = 2'd1;
    localparam logic [1:0] REG_SOCKET_MAP = 2'd2;

    // Frame summary handed from the parser to the verdict stage
    typedef struct packed {
        logic             match;
        logic [POS_W-1:0] length;
        logic [7:0]       queue;
    } parse_result_t;

endpackage

@@ src/udpc_parse.sv @@
`timescale 1ns / 1ps

module udpc_parse (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic [7:0]              data_byte,
    input  logic                    data_last,
    input  logic [7:0]              data_queue,
    input  logic [15:0]             port_low,
    input  logic [15:0]             port_high,
    output udpc_pkg::parse_result_t result
);
    import udpc_pkg::*;

    localparam logic [15:0] ETH_IPV4  = 16'h0800;
    localparam logic [15:0] ETH_IPV6  = 16'h86DD;
    localparam logic [7:0]  PROTO_UDP = 8'd17;

    localparam logic [POS_W-1:0] POS_FIRST   = POS_W'(0);
    localparam logic [POS_W-1:0] POS_ETH_HI  = POS_W'(12);
    localparam logic [POS_W-1:0] POS_ETH_LO  = POS_W'(13);
    localparam logic [POS_W-1:0] POS_IP_VER  = POS_W'(14);
    localparam logic [POS_W-1:0] POS_IP_PAY  = POS_W'(15);
    localparam logic [POS_W-1:0] POS_V4_FRAG = POS_W'(20);
    localparam logic [POS_W-1:0] POS_V4_OFF  = POS_W'(21);
    localparam logic [POS_W-1:0] POS_V4_PROT = POS_W'(23);
    localparam logic [POS_W-1:0] POS_V6_NEXT = POS_W'(20);
    localparam logic [POS_W-1:0] POS_MAX     = POS_W'(MAX_FRAME_BYTES);

    localparam logic [6:0] UDP_AT_BASE = 7'd14;
    localparam logic [6:0] UDP_AT_V6   = 7'd54;
    localparam logic [6:0] NEED_V4_MIN = 7'd34;
    localparam logic [6:0] NEED_V6     = 7'd62;
    localparam logic [6:0] UDP_HDR_LEN = 7'd8;

    logic [POS_W-1:0] pos_reg,       pos_next;
    logic [7:0]       queue_reg,     queue_next;
    logic [15:0]      ethertype_reg, ethertype_next;
    logic [3:0]       hdr_words_reg, hdr_words_next;
    logic             rejected_reg,  rejected_next;
    logic [4:0]       frag_hi_reg,   frag_hi_next;
    logic [15:0]      dport_reg,     dport_next;

    logic             is_v4;
    logic             is_v6;
    logic [6:0]       udp_at;
    logic [6:0]       udp_end;
    logic [6:0]       need;
    logic [POS_W-1:0] udp_dport_hi;
    logic [POS_W-1:0] udp_dport_lo;
    logic [POS_W-1:0] pos_upd;
    logic [7:0]       queue_upd;
    logic [15:0]      ethertype_upd;
    logic [3:0]       hdr_words_upd;
    logic             rejected_upd;
    logic [4:0]       frag_hi_upd;
    logic [15:0]      dport_upd;

    always_comb
    begin
        // Type is judged on the value held before this byte
        is_v4 = (ethertype_reg == ETH_IPV4);
        is_v6 = (ethertype_reg == ETH_IPV6);

        queue_upd     = (pos_reg == POS_FIRST) ? data_queue : queue_reg;
        ethertype_upd = ethertype_reg;
        if (pos_reg == POS_ETH_HI)
        begin
            ethertype_upd[15:8] = data_byte;
        end
        if (pos_reg == POS_ETH_LO)
        begin
            ethertype_upd[7:0] = data_byte;
        end

        hdr_words_upd = hdr_words_reg;
        rejected_upd  = rejected_reg;
        frag_hi_upd   = frag_hi_reg;
        if (pos_reg == POS_IP_VER)
        begin
            if (is_v4)
            begin
                hdr_words_upd = data_byte[3:0];
                if (data_byte[7:4] != 4'd4)
                begin
                    rejected_upd = 1'b1;
                end
            end
            else if (is_v6 && (data_byte[7:4] != 4'd6))
            begin
                rejected_upd = 1'b1;
            end
        end
        if (is_v4 && (pos_reg == POS_V4_FRAG))
        begin
            frag_hi_upd = data_byte[4:0];
        end
        // Reject a non-zero fragment offset; the flag bits are not checked
        if (is_v4 && (pos_reg == POS_V4_OFF) && ((frag_hi_reg != 5'd0) || (data_byte != 8'd0)))
        begin
            rejected_upd = 1'b1;
        end
        if (is_v4 && (pos_reg == POS_V4_PROT) && (data_byte != PROTO_UDP))
        begin
            rejected_upd = 1'b1;
        end
        if (is_v6 && (pos_reg == POS_V6_NEXT) && (data_byte != PROTO_UDP))
        begin
            rejected_upd = 1'b1;
        end

        udp_at       = is_v4 ? (UDP_AT_BASE + {1'b0, hdr_words_upd, 2'b00}) : UDP_AT_V6;
        udp_dport_hi = POS_W'(udp_at) + POS_W'(2);
        udp_dport_lo = POS_W'(udp_at) + POS_W'(3);
        dport_upd    = dport_reg;
        if ((is_v4 || is_v6) && (pos_reg >= POS_IP_PAY))
        begin
            if (pos_reg == udp_dport_hi)
            begin
                dport_upd[15:8] = data_byte;
            end
            if (pos_reg == udp_dport_lo)
            begin
                dport_upd[7:0] = data_byte;
            end
        end

        pos_upd = (pos_reg < POS_MAX) ? (pos_reg + POS_W'(1)) : pos_reg;

        udp_end = udp_at + UDP_HDR_LEN;
        if (is_v4)
        begin
            need = (udp_end > NEED_V4_MIN) ? udp_end : NEED_V4_MIN;
        end
        else
        begin
            need = NEED_V6;
        end

        result.match  = (is_v4 || is_v6) && !rejected_upd && (pos_upd >= POS_W'(need))
                        && (dport_upd >= port_low) && (dport_upd <= port_high);
        result.length = pos_upd;
        result.queue  = queue_upd;

        // Clear all per-frame state after the last word
        if (data_last)
        begin
            pos_next       = '0;
            queue_next     = '0;
            ethertype_next = '0;
            hdr_words_next = '0;
            rejected_next  = 1'b0;
            frag_hi_next   = '0;
            dport_next     = '0;
        end
        else
        begin
            pos_next       = pos_upd;
            queue_next     = queue_upd;
            ethertype_next = ethertype_upd;
            hdr_words_next = hdr_words_upd;
            rejected_next  = rejected_upd;
            frag_hi_next   = frag_hi_upd;
            dport_next     = dport_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            queue_reg     <= '0;
            ethertype_reg <= '0;
            hdr_words_reg <= '0;
            rejected_reg  <= 1'b0;
            frag_hi_reg   <= '0;
            dport_reg     <= '0;
        end
        else if (step)
        begin
            pos_reg       <= pos_next;
            queue_reg     <= queue_next;
            ethertype_reg <= ethertype_next;
            hdr_words_reg <= hdr_words_next;
            rejected_reg  <= rejected_next;
            frag_hi_reg   <= frag_hi_next;
            dport_reg     <= dport_next;
        end
    end

endmodule

@@ src/udp_port_range_packet_classifier.sv @@
`timescale 1ns / 1ps
// UDP destination port range classifier.
// Frame channel: one frame byte per word (frame_byte, frame_last, rx_queue),
// moved when frame_valid is high and frame_stall is low. rx_queue counts only
// on the first word of a frame. Result channel: one word per frame, on its
// last byte, carrying the verdict (pass, drop, redirect), the frame length,
// the queue and the four running 48-bit counters after that frame; moved
// when result_valid is high and result_stall is low.
// A last byte is parsed in the input register stage and its result is
// loaded into the result register once that register is free.
// Throughput: one frame byte every cycle while frame_stall is low; the
// parser state is updated by one pass of short logic between the input
// and result registers.
// Stall: a waiting result holds; further bytes are still taken until a last
// byte sits in the input register while the result register is full and
// result_stall is high, and only then is frame_stall raised.
// Reset clears the parser state, counters and both valid flags, and sets the
// port range to 40000..50000 with no socket bound. Registers sit on an APB
// port at byte addresses 0, 8 and 16; write them only while the block is idle.

module udp_port_range_packet_classifier (
    input  logic        clk,
    input  logic        rst_n,
    // frame channel
    input  logic        frame_valid,
    output logic        frame_stall,
    input  logic [7:0]  frame_byte,
    input  logic        frame_last,
    input  logic [7:0]  rx_queue,
    // result channel
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  verdict,
    output logic [13:0] frame_length,
    output logic [7:0]  out_queue,
    output logic [47:0] matched_packets,
    output logic [47:0] matched_bytes,
    output logic [47:0] dropped_packets,
    output logic [47:0] redirected_packets,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import udpc_pkg::*;

    `include "udp_port_range_packet_classifier_macros.svh"

    // configuration registers
    logic [15:0] port_low_reg;
    logic [15:0] port_high_reg;
    logic [63:0] socket_map_reg;
    logic        cfg_write;
    logic [1:0]  cfg_index;

    // input register
    logic        in_valid_reg, in_valid_next;
    logic [7:0]  in_byte_reg;
    logic        in_last_reg;
    logic [7:0]  in_queue_reg;

    // result register and counters
    logic             result_valid_reg, result_valid_next;
    logic [1:0]       verdict_reg,      verdict_next;
    logic [POS_W-1:0] length_reg;
    logic [7:0]       queue_reg;
    logic [CNT_W-1:0] pkt_cnt_reg,      pkt_cnt_next;
    logic [CNT_W-1:0] byte_cnt_reg,     byte_cnt_next;
    logic [CNT_W-1:0] drop_cnt_reg,     drop_cnt_next;
    logic [CNT_W-1:0] redir_cnt_reg,    redir_cnt_next;

    parse_result_t parse;
    logic          frame_take;
    logic          result_free;
    logic          stage_move;
    logic          result_load;
    logic          bound;

    // ---------------------------------------------------------------
    // Configuration port: always ready, write on the access phase
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:3];

    always_comb
    begin
        unique case (cfg_index)
            REG_PORT_LOW:   prdata = {48'd0, port_low_reg};
            REG_PORT_HIGH:  prdata = {48'd0, port_high_reg};
            REG_SOCKET_MAP: prdata = socket_map_reg;
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_low_reg   <= 16'd40000;
            port_high_reg  <= 16'd50000;
            socket_map_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_PORT_LOW:   port_low_reg   <= pwdata[15:0];
                REG_PORT_HIGH:  port_high_reg  <= pwdata[15:0];
                REG_SOCKET_MAP: socket_map_reg <= pwdata;
                default:        ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Flow control: a byte leaves the input register unless it is a
    // last byte and the result register cannot take its verdict.
    // ---------------------------------------------------------------
    assign result_free = !result_valid_reg || !result_stall;
    assign stage_move  = in_valid_reg && (!in_last_reg || result_free);
    assign result_load = stage_move && in_last_reg;
    assign frame_stall = in_valid_reg && !stage_move;
    assign frame_take  = frame_valid && !frame_stall;

    assign in_valid_next = frame_take || (in_valid_reg && !stage_move);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload holds while stalled
    always_ff @(posedge clk)
    begin
        if (frame_take)
        begin
            in_byte_reg  <= frame_byte;
            in_last_reg  <= frame_last;
            in_queue_reg <= rx_queue;
        end
    end

    // ---------------------------------------------------------------
    // Header parser: per-frame state, advanced once per moved word
    // ---------------------------------------------------------------
    udpc_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (stage_move),
        .data_byte  (in_byte_reg),
        .data_last  (in_last_reg),
        .data_queue (in_queue_reg),
        .port_low   (port_low_reg),
        .port_high  (port_high_reg),
        .result     (parse)
    );

    // ---------------------------------------------------------------
    // Verdict and counters. A queue beyond the slot count never has a
    // bound socket, so a match there is dropped.
    // ---------------------------------------------------------------
    assign bound = (parse.queue < 8'(QUEUE_SLOTS))
                   && socket_map_reg[parse.queue[QUEUE_IDX_W-1:0]];

    always_comb
    begin
        verdict_next   = VERDICT_PASS;
        pkt_cnt_next   = pkt_cnt_reg;
        byte_cnt_next  = byte_cnt_reg;
        drop_cnt_next  = drop_cnt_reg;
        redir_cnt_next = redir_cnt_reg;
        if (parse.match)
        begin
            pkt_cnt_next  = pkt_cnt_reg + CNT_W'(1);
            byte_cnt_next = byte_cnt_reg + CNT_W'(parse.length);
            if (bound)
            begin
                verdict_next   = VERDICT_REDIRECT;
                redir_cnt_next = redir_cnt_reg + CNT_W'(1);
            end
            else
            begin
                verdict_next  = VERDICT_DROP;
                drop_cnt_next = drop_cnt_reg + CNT_W'(1);
            end
        end
    end

    assign result_valid_next = result_load || (result_valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
            pkt_cnt_reg      <= '0;
            byte_cnt_reg     <= '0;
            drop_cnt_reg     <= '0;
            redir_cnt_reg    <= '0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (result_load)
            begin
                pkt_cnt_reg   <= pkt_cnt_next;
                byte_cnt_reg  <= byte_cnt_next;
                drop_cnt_reg  <= drop_cnt_next;
                redir_cnt_reg <= redir_cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_load)
        begin
            verdict_reg <= verdict_next;
            length_reg  <= parse.length;
            queue_reg   <= parse.queue;
        end
    end

    assign result_valid       = result_valid_reg;
    assign verdict            = verdict_reg;
    assign frame_length       = length_reg;
    assign out_queue          = queue_reg;
    assign matched_packets    = pkt_cnt_reg;
    assign matched_bytes      = byte_cnt_reg;
    assign dropped_packets    = drop_cnt_reg;
    assign redirected_packets = redir_cnt_reg;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // Stall only for a last byte whose verdict has nowhere to go
    `UDPC_ASSERT_NOW(a_stall_cause, clk, rst_n, frame_stall,
        in_valid_reg && in_last_reg && result_valid_reg && result_stall)
    // Packet counter advances exactly for a drop or a redirect
    `UDPC_ASSERT_NEXT(a_pkt_step, clk, rst_n, result_load,
        (pkt_cnt_reg - $past(pkt_cnt_reg)) == CNT_W'(verdict_reg != VERDICT_PASS))
    // Every match is either dropped or redirected
    `UDPC_ASSERT_NEXT(a_pkt_split, clk, rst_n, result_load,
        (pkt_cnt_reg - $past(pkt_cnt_reg)) ==
        ((drop_cnt_reg - $past(drop_cnt_reg)) + (redir_cnt_reg - $past(redir_cnt_reg))))

endmodule
